/* hw/rtl/cnms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_pkg: shared types and constants for Canny non-maximum suppression
// Field widths, register defaults, tangent thresholds and stream layouts.
// ----------------------------------------------------------------------------
package cnms_pkg;

    // Pixel fields
    localparam int GRAD_BITS = 11;
    localparam int MAG_BITS  = 8;
    localparam int DIR_BITS  = 2;

    // Frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_W      = FH_W;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = CFG_ADDR_W'(1);

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // Tangent thresholds in 16-bit fraction: tan 22.5 and tan 67.5
    localparam int TAN_FRAC_BITS = 16;
    localparam int TAN_W         = 18;
    localparam logic [TAN_W-1:0] TAN_22_5 = TAN_W'(27146);
    localparam logic [TAN_W-1:0] TAN_67_5 = TAN_W'(158218);
    localparam int PROD_W = GRAD_BITS + TAN_W;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [DIR_BITS-1:0] {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } t_dir_bin;

    // One window column: bottom, middle (with direction) and top magnitude
    typedef struct packed {
        logic [MAG_BITS-1:0] bot;
        t_dir_bin            dir;
        logic [MAG_BITS-1:0] mid;
        logic [MAG_BITS-1:0] top;
    } t_win_col;

    // Middle line store entry
    typedef struct packed {
        t_dir_bin            dir;
        logic [MAG_BITS-1:0] mag;
    } t_mid_entry;

    // Position flags of the center pixel
    typedef struct packed {
        logic produce;
        logic border;
        logic last;
    } t_pos_info;

    // One result
    typedef struct packed {
        logic                last;
        t_dir_bin            dir;
        logic [MAG_BITS-1:0] value;
    } t_result;

endpackage

/* hw/rtl/cnms_dir.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_dir: gradient direction quantizer
// Folds the gradient into 0..180 degrees and bins it to 0/45/90/135 using
// fixed-point tangent comparisons.
// ----------------------------------------------------------------------------
module cnms_dir
    import cnms_pkg::*;
(
    input  logic signed [GRAD_BITS-1:0] i_grad_x,
    input  logic signed [GRAD_BITS-1:0] i_grad_y,
    output t_dir_bin                    o_dir
);

    logic signed [GRAD_BITS:0] gx_e, gy_e, gx_f, gy_f, gx_abs;
    logic [GRAD_BITS-1:0]      ax, ay;
    logic [PROD_W-1:0]         lhs, lo_thr, hi_thr;

    // fold into upper half plane
    always_comb begin
        gx_e = {i_grad_x[GRAD_BITS-1], i_grad_x};
        gy_e = {i_grad_y[GRAD_BITS-1], i_grad_y};
        gx_f = i_grad_y[GRAD_BITS-1] ? -gx_e : gx_e;
        gy_f = i_grad_y[GRAD_BITS-1] ? -gy_e : gy_e;
        gx_abs = gx_f[GRAD_BITS] ? -gx_f : gx_f;
        ax = gx_abs[GRAD_BITS-1:0];
        ay = gy_f[GRAD_BITS-1:0];
    end

    // scaled comparands
    assign lhs    = PROD_W'(ay) << TAN_FRAC_BITS;
    assign lo_thr = PROD_W'(ax) * PROD_W'(TAN_22_5);
    assign hi_thr = PROD_W'(ax) * PROD_W'(TAN_67_5);

    // bin select
    always_comb begin
        if (ay == '0) begin
            o_dir = DIR_0;
        end else if (!gx_f[GRAD_BITS]) begin
            if (lhs < lo_thr)      o_dir = DIR_0;
            else if (lhs < hi_thr) o_dir = DIR_45;
            else                   o_dir = DIR_90;
        end else begin
            if (lhs > hi_thr)      o_dir = DIR_90;
            else if (lhs > lo_thr) o_dir = DIR_135;
            else                   o_dir = DIR_0;
        end
    end

endmodule

/* hw/rtl/cnms_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_fifo: result queue
// Small register queue between the processing stage and the output stream;
// reports its fill level for input flow control.
// ----------------------------------------------------------------------------
module cnms_fifo
    import cnms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_result               i_data,
    input  logic                  i_ready,
    output logic                  o_valid,
    output t_result               o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic                    pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/canny_non_max_suppression_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canny_non_max_suppression_top: Canny non-maximum suppression
// Path: a transfer that completes a 3x3 window (the pixel W+1 items later in
//   raster order) goes through the input stage register into the output queue.
// Throughput: one item per cycle while the output queue has room, set by one
//   read and one write per cycle on each line store; a small output queue
//   absorbs downstream stalls.
// Reset: synchronous, active low; clears counters, window and queue and sets
//   640x480. Line stores are not cleared (stale entries never reach a result).
// ----------------------------------------------------------------------------
module canny_non_max_suppression_top
    import cnms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // pixel stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // grad_x[10:0] grad_y[21:11] magnitude[29:22]
    input  logic                   s_axis_tuser,   // req_type (1 = flush)
    // result stream out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // anchor_value[7:0] direction_bin[9:8]
    output logic                   m_axis_tlast    // frame_last
);

    localparam int GX_LO  = 0;
    localparam int GY_LO  = GRAD_BITS;
    localparam int MAG_LO = 2 * GRAD_BITS;

    // configuration
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [FW_W-1:0] w_eff, w_m1;
    logic [FH_W-1:0] h_eff, h_m1;

    // position
    logic [COL_W-1:0] r_col, n_col, cc;
    logic [ROW_W-1:0] r_row, n_row, cr;
    logic             xfer, skip, proc, col_ge1, row_ok;
    t_pos_info        pos;

    // stage registers
    logic                        r_s0_valid;
    logic                        r_s0_flush;
    logic signed [GRAD_BITS-1:0] r_s0_gx, r_s0_gy;
    logic [MAG_BITS-1:0]         r_s0_mag;
    logic [COL_W-1:0]            r_s0_col;
    t_pos_info                   r_s0_info;

    // line stores and forwarding
    logic [MAG_BITS-1:0] upper_store  [MAX_WIDTH];
    t_mid_entry          middle_store [MAX_WIDTH];
    logic [MAG_BITS-1:0] r_up_q, r_fwd_up, up_eff, up_wdata;
    t_mid_entry          r_mid_q, r_fwd_mid, mid_eff, mid_wdata;
    logic                r_hit;

    // window and result
    t_win_col            r_win [3];
    t_win_col            new_col, left, cen, right;
    t_dir_bin            q_dir;
    logic [MAG_BITS-1:0] n1, n2;
    t_result             res;
    logic                push;
    logic [FIFO_CNT_W-1:0] fifo_count;
    t_result             out_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    always_comb begin
        if (r_frame_width < FW_W'(MIN_DIM))        w_eff = FW_W'(MIN_DIM);
        else if (r_frame_width > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
        else                                       w_eff = r_frame_width;
        if (r_frame_height < FH_W'(MIN_DIM))         h_eff = FH_W'(MIN_DIM);
        else if (r_frame_height > FH_W'(MAX_HEIGHT)) h_eff = FH_W'(MAX_HEIGHT);
        else                                         h_eff = r_frame_height;
        w_m1 = w_eff - 1'b1;
        h_m1 = h_eff - 1'b1;
    end

    // input transfer; a flush at frame start is dropped
    assign xfer = s_axis_tvalid && s_axis_tready;
    assign skip = s_axis_tuser && (r_row == '0) && (r_col == '0);
    assign proc = xfer && !skip;

    // raster counters
    always_comb begin
        if ({1'b0, r_row} >= ({1'b0, h_eff} + 1'b1)) begin
            n_row = '0;
            n_col = '0;
        end else if (({1'b0, r_col} + 1'b1) >= w_eff) begin
            n_row = r_row + 1'b1;
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + 1'b1;
        end
    end

    // center pixel of the window that this transfer completes
    always_comb begin
        col_ge1 = (r_col != '0);
        if (col_ge1) begin
            row_ok = (r_row >= ROW_W'(1));
            cr     = r_row - ROW_W'(1);
            cc     = r_col - 1'b1;
        end else begin
            row_ok = (r_row >= ROW_W'(2));
            cr     = r_row - ROW_W'(2);
            cc     = w_m1[COL_W-1:0];
        end
        pos.produce = row_ok && (cr <= h_m1);
        pos.border  = (cr == '0) || (cr >= h_m1) || (cc == '0) || ({1'b0, cc} >= w_m1);
        pos.last    = (cr == h_m1) && ({1'b0, cc} == w_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (proc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_s0_flush <= s_axis_tuser;
            r_s0_gx    <= s_axis_tdata[GX_LO +: GRAD_BITS];
            r_s0_gy    <= s_axis_tdata[GY_LO +: GRAD_BITS];
            r_s0_mag   <= s_axis_tdata[MAG_LO +: MAG_BITS];
            r_s0_col   <= r_col;
            r_s0_info  <= pos;
            // same-address write in this cycle is forwarded
            r_hit      <= r_s0_valid && (r_s0_col == r_col);
            r_fwd_up   <= up_wdata;
            r_fwd_mid  <= mid_wdata;
        end
    end

    // line stores: write of the item in stage, read for the incoming item
    always_ff @(posedge i_clk) begin
        if (r_s0_valid) begin
            upper_store[r_s0_col]  <= up_wdata;
            middle_store[r_s0_col] <= mid_wdata;
        end
        if (proc) begin
            r_up_q  <= upper_store[r_col];
            r_mid_q <= middle_store[r_col];
        end
    end

    // direction of the staged pixel
    cnms_dir u_dir (
        .i_grad_x (r_s0_gx),
        .i_grad_y (r_s0_gy),
        .o_dir    (q_dir)
    );

    // current pixel column and store write data (flush acts as a zero pixel)
    always_comb begin
        up_eff        = r_hit ? r_fwd_up  : r_up_q;
        mid_eff       = r_hit ? r_fwd_mid : r_mid_q;
        mid_wdata.mag = r_s0_flush ? '0 : r_s0_mag;
        mid_wdata.dir = r_s0_flush ? DIR_0 : q_dir;
        up_wdata      = mid_eff.mag;
        new_col.top   = up_eff;
        new_col.mid   = mid_eff.mag;
        new_col.dir   = mid_eff.dir;
        new_col.bot   = mid_wdata.mag;
    end

    // 3x3 window columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (r_s0_valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= new_col;
        end
    end

    // suppression along the center's direction
    always_comb begin
        left  = r_win[1];
        cen   = r_win[2];
        right = new_col;
        case (cen.dir)
            DIR_0: begin
                n1 = left.mid;
                n2 = right.mid;
            end
            DIR_45: begin
                n1 = left.top;
                n2 = right.bot;
            end
            DIR_90: begin
                n1 = cen.top;
                n2 = cen.bot;
            end
            default: begin
                n1 = right.top;
                n2 = left.bot;
            end
        endcase
        res.dir  = cen.dir;
        res.last = r_s0_info.last;
        if (r_s0_info.border || ((cen.mid > n1) && (cen.mid > n2))) begin
            res.value = cen.mid;
        end else begin
            res.value = '0;
        end
    end

    assign push = r_s0_valid && r_s0_info.produce;

    // output queue
    cnms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .o_count (fifo_count)
    );

    // room for every item in flight
    assign s_axis_tready = (fifo_count + FIFO_CNT_W'(r_s0_valid)) < FIFO_CNT_W'(FIFO_DEPTH);

    assign m_axis_tdata = OUT_TDATA_W'({out_res.dir, out_res.value});
    assign m_axis_tlast = out_res.last;

endmodule

/* hw/rtl/cnms_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_checker: port-level checks for the suppression block
// Watches reset, flow control and output stall behavior; bound to the top.
// ----------------------------------------------------------------------------
module cnms_checker
    import cnms_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // reset empties the result queue
    a_rst_no_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // reset leaves the input side open
    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // an empty queue never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with nothing waiting at the output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind canny_non_max_suppression_top cnms_checker u_cnms_checker (.*);
